FILE: hdl/crp_pkg.sv
package crp_pkg;

  // Default frame side for the top-level parameter.
  localparam int unsigned MAX_SIDE_DEF = 256;

  // Field widths.
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned IDX8_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 9;
  localparam int unsigned SIDE_W    = 9;

  // Arithmetic widths: multiplier operand, signed offset and squared distance.
  localparam int unsigned MUL_W = COORD_W + 1;
  localparam int unsigned DX_W  = COORD_W + 2;
  localparam int unsigned SQ_W  = 2 * MUL_W;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SHAPE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND   = 2'd2;

  // Register reset values.
  localparam logic [SIDE_W-1:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [SIDE_W-1:0] FRAME_HEIGHT_RST = 9'd256;
  localparam logic [CHAR_W-1:0] BACKGROUND_RST   = 8'd32;

  // Shape bytes.
  localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'h43;
  localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h63;

  // One unit in Q15.8, and its square in Q30.16.
  localparam logic signed [COORD_W-1:0] ONE_Q8 = 24'sd256;
  localparam int unsigned               ONE_SQ = 65536;

endpackage

FILE: hdl/crp_if.sv
// Command channel: one item per clear, circle or pixel read.
interface crp_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [7:0]                  shape_char;
  logic [7:0]                  paint_char;
  logic signed [23:0]          center_x;
  logic signed [23:0]          center_y;
  logic signed [23:0]          radius;
  logic [7:0]                  read_col;
  logic [7:0]                  read_row;

  modport source (
    output valid, kind, shape_char, paint_char, center_x, center_y, radius,
           read_col, read_row,
    input  ready
  );
  modport sink (
    input  valid, kind, shape_char, paint_char, center_x, center_y, radius,
           read_col, read_row,
    output ready
  );
endinterface

// Result channel: one item per command.
interface crp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] pixel_value;

  modport source (output valid, status, pixel_value, input ready);
  modport sink (input valid, status, pixel_value, output ready);
endinterface

// Register write channel.
interface crp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/circle_raster_painter_top.sv
// Byte framebuffer painter.
//
// The command channel in_i takes clear, circle and pixel-read items; each
// item gives exactly one result item on out_o (status and pixel byte).
// Registers (frame width, frame height, background byte) are written on
// cfg_i, which is always ready; write them only while the block is idle.
// The block works on one item at a time and drops in_i.ready meanwhile.
// A clear item scans the frame, with its sides clipped to MAX_SIDE: the scan
// counter writes one pixel per cycle through the single memory port. A
// valid circle item first lets one shared multiplier form the squared
// centre offsets and squared radii in turn, then runs the same
// one-pixel-per-cycle scan, where the squared distance is stepped by additions
// alone. A pixel read passes through a read state before the finish; a rejected
// circle, an out-of-frame read, an empty frame or an unused kind goes straight there.
// The result sits in an output register, so the next item is taken while
// the previous result still waits; a stalled receiver holds the result
// stable and blocks only the finish of the following item.
// Reset restores the register defaults (256, 256, 32) and empties the
// output; frame contents stay undefined until a clear or circle writes them.
module circle_raster_painter_top #(
  parameter int unsigned MAX_SIDE = crp_pkg::MAX_SIDE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  crp_in_if.sink   in_i,
  crp_out_if.source out_o,
  crp_cfg_if.sink  cfg_i
);
  import crp_pkg::*;

  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(MAX_SIDE + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // Multiplier steps: each squares one operand, the result lands a step later.
  localparam logic [2:0] MUL_CX   = 3'd0;
  localparam logic [2:0] MUL_CY   = 3'd1;
  localparam logic [2:0] MUL_R    = 3'd2;
  localparam logic [2:0] MUL_RIN  = 3'd3;
  localparam logic [2:0] MUL_LAST = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [2:0]          step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic [SIDE_W-1:0]   frame_w_q, frame_h_q;
  logic [CHAR_W-1:0]   bg_q;

  logic [CW-1:0]       col_q, col_d, row_q, row_d;
  logic [AW-1:0]       addr_q, addr_d, base_q, base_d;
  logic                clear_q, clear_d, filled_q, filled_d, rd_ok_q, rd_ok_d;
  logic [CHAR_W-1:0]   paint_q, paint_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic signed [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d, rad_q, rad_d;
  logic signed [DX_W-1:0]    dx_q, dx_d, dy_q, dy_d;
  logic [SQ_W-1:0]     cx2_q, cx2_d, dx2_q, dx2_d, dy2_q, dy2_d;
  logic [SQ_W-1:0]     outer_q, outer_d, inner_q, inner_d;
  logic signed [SQ_W-1:0]    prod_q;
  logic signed [SQ_W-1:0]    prod_d;
  logic signed [MUL_W-1:0]   mul_a;

  logic [STATUS_W-1:0] out_status_q;
  logic [CHAR_W-1:0]   out_pixel_q;

  logic [CW-1:0]       eff_w, eff_h;
  logic                in_acc, out_load, wr_en, hit, last_col, last_row;
  logic [SQ_W-1:0]     d2;
  logic [CHAR_W-1:0]   wr_data, rd_data;
  logic [AW-1:0]       rd_addr;

  // Frame sides clipped to the store.
  assign eff_w = (32'(frame_w_q) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(frame_w_q);
  assign eff_h = (32'(frame_h_q) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(frame_h_q);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= FRAME_WIDTH_RST;
      frame_h_q <= FRAME_HEIGHT_RST;
      bg_q      <= BACKGROUND_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_FRAME_WIDTH:  frame_w_q <= cfg_i.data;
        CFG_FRAME_HEIGHT: frame_h_q <= cfg_i.data;
        CFG_BACKGROUND:   bg_q      <= cfg_i.data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared squaring unit, fed by the multiplier step.
  always_comb begin
    case (step_q)
      MUL_CX:  mul_a = MUL_W'(cx_q);
      MUL_CY:  mul_a = MUL_W'(cy_q);
      MUL_R:   mul_a = MUL_W'(rad_q);
      default: mul_a = MUL_W'(rad_q) - MUL_W'(ONE_Q8);
    endcase
  end
  assign prod_d = mul_a * mul_a;

  // Pixel test: squared distance against the squared outer and inner radii.
  assign d2       = dx2_q + dy2_q;
  assign hit      = (d2 <= outer_q) && (filled_q || (d2 > inner_q));
  assign last_col = (col_q == eff_w - CW'(1));
  assign last_row = (row_q == eff_h - CW'(1));
  assign wr_data  = clear_q ? bg_q : paint_q;
  assign rd_addr  = AW'(in_i.read_row) * AW'(MAX_SIDE) + AW'(in_i.read_col);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    col_d    = col_q;
    row_d    = row_q;
    addr_d   = addr_q;
    base_d   = base_q;
    clear_d  = clear_q;
    filled_d = filled_q;
    rd_ok_d  = rd_ok_q;
    paint_d  = paint_q;
    status_d = status_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    rad_d    = rad_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    cx2_d    = cx2_q;
    dx2_d    = dx2_q;
    dy2_d    = dy2_q;
    outer_d  = outer_q;
    inner_d  = inner_q;
    wr_en    = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          status_d = STATUS_OK;
          rd_ok_d  = 1'b0;
          col_d    = '0;
          row_d    = '0;
          addr_d   = '0;
          base_d   = '0;
          step_d   = MUL_CX;
          paint_d  = in_i.paint_char;
          cx_d     = in_i.center_x;
          cy_d     = in_i.center_y;
          rad_d    = in_i.radius;
          filled_d = (in_i.shape_char == SHAPE_FILLED);
          state_d  = ST_FIN;
          case (in_i.kind)
            KIND_CLEAR: begin
              clear_d = 1'b1;
              if (eff_w != '0 && eff_h != '0) begin
                state_d = ST_SCAN;
              end
            end
            KIND_CIRCLE: begin
              clear_d = 1'b0;
              if (in_i.radius < ONE_Q8 ||
                  (in_i.shape_char != SHAPE_FILLED &&
                   in_i.shape_char != SHAPE_OUTLINE)) begin
                status_d = STATUS_BAD_SHAPE;
              end else if (eff_w != '0 && eff_h != '0) begin
                state_d = ST_MUL;
              end
            end
            KIND_READ: begin
              if (32'(in_i.read_col) >= 32'(eff_w) ||
                  32'(in_i.read_row) >= 32'(eff_h)) begin
                status_d = STATUS_RANGE;
              end else begin
                rd_ok_d = 1'b1;
                addr_d  = rd_addr;
                state_d = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end

      ST_MUL: begin
        step_d = step_q + 3'd1;
        case (step_q)
          MUL_CY:  cx2_d   = prod_q;
          MUL_R:   dy2_d   = prod_q;
          MUL_RIN: outer_d = prod_q;
          MUL_LAST: begin
            inner_d = prod_q;
            dx2_d   = cx2_q;
            dx_d    = -DX_W'(cx_q);
            dy_d    = -DX_W'(cy_q);
            state_d = ST_SCAN;
          end
          default: ;
        endcase
      end

      ST_SCAN: begin
        wr_en = clear_q || hit;
        if (last_col) begin
          col_d  = '0;
          row_d  = row_q + CW'(1);
          base_d = base_q + AW'(MAX_SIDE);
          addr_d = base_q + AW'(MAX_SIDE);
          dx_d   = -DX_W'(cx_q);
          dx2_d  = cx2_q;
          dy_d   = dy_q + DX_W'(ONE_Q8);
          dy2_d  = dy2_q + (SQ_W'(dy_q) << 9) + SQ_W'(ONE_SQ);
          if (last_row) begin
            state_d = ST_FIN;
          end
        end else begin
          col_d  = col_q + CW'(1);
          addr_d = addr_q + AW'(1);
          dx_d   = dx_q + DX_W'(ONE_Q8);
          dx2_d  = dx2_q + (SQ_W'(dx_q) << 9) + SQ_W'(ONE_SQ);
        end
      end

      ST_RD: begin
        state_d = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    col_q    <= col_d;
    row_q    <= row_d;
    addr_q   <= addr_d;
    base_q   <= base_d;
    clear_q  <= clear_d;
    filled_q <= filled_d;
    rd_ok_q  <= rd_ok_d;
    paint_q  <= paint_d;
    status_q <= status_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    rad_q    <= rad_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    cx2_q    <= cx2_d;
    dx2_q    <= dx2_d;
    dy2_q    <= dy2_d;
    outer_q  <= outer_d;
    inner_q  <= inner_d;
    prod_q   <= prod_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_pixel_q  <= rd_ok_q ? rd_data : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.pixel_value = out_pixel_q;

  crp_frame_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_frame_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .addr_i   (addr_q),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

endmodule

FILE: hdl/crp_frame_mem.sv
module crp_frame_mem #(
  parameter int unsigned DEPTH = crp_pkg::MAX_SIDE_DEF * crp_pkg::MAX_SIDE_DEF,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wr_data_i,
  output logic [7:0]    rd_data_o
);
  import crp_pkg::*;

  logic [CHAR_W-1:0] mem_q [DEPTH];
  logic [CHAR_W-1:0] rd_data_q;

  // Single-port frame store with a registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/crp_checker.sv
module crp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic [7:0] pixel_value_i
);
  import crp_pkg::*;

  // A result waiting on the receiver holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(status_i) && $stable(pixel_value_i))
    else $error("result changed while stalled");

  // Only one item is in work: the command channel closes after each item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while another is in work");

  // Status is one of the three defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == STATUS_OK || status_i == STATUS_BAD_SHAPE ||
                     status_i == STATUS_RANGE))
    else $error("undefined status code");

  // Failed items carry no pixel byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != STATUS_OK |-> pixel_value_i == '0)
    else $error("pixel byte on a failed item");

endmodule

bind circle_raster_painter_top crp_checker u_crp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .pixel_value_i(out_o.pixel_value)
);

FILE: sim/paint_check_pkg.sv
`timescale 1ns / 100ps

package paint_check_pkg;
  import crp_pkg::*;

  // Kind code that the block answers without doing anything.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned SIDE         = MAX_SIDE_DEF;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [CHAR_W-1:0]         shape_char;
    logic [CHAR_W-1:0]         paint_char;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] radius;
    logic [IDX8_W-1:0]         read_col;
    logic [IDX8_W-1:0]         read_row;
  } paint_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   pixel_value;
  } paint_result_t;

  // Shadow framebuffer: predicts each result item and compares the block's
  // results against them in order.
  class frame_scoreboard;
    bit [CHAR_W-1:0] pixels [SIDE*SIDE];
    bit              written [SIDE*SIDE];
    bit [SIDE_W-1:0] width_reg;
    bit [SIDE_W-1:0] height_reg;
    bit [CHAR_W-1:0] background;
    paint_result_t   pending_results[$];
    int unsigned     mismatches;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      background = BACKGROUND_RST;
      mismatches = 0;
    endfunction

    // Frame sides in use; larger settings act as the full side.
    function int unsigned cols();
      return (width_reg > SIDE) ? SIDE : width_reg;
    endfunction

    function int unsigned rows();
      return (height_reg > SIDE) ? SIDE : height_reg;
    endfunction

    function bit is_written(int unsigned col, int unsigned row);
      return written[row*SIDE + col];
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void set_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH: begin
          width_reg = data;
        end
        CFG_FRAME_HEIGHT: begin
          height_reg = data;
        end
        CFG_BACKGROUND: begin
          background = data[CHAR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void put_pixel(int unsigned col, int unsigned row, bit [CHAR_W-1:0] value);
      pixels[row*SIDE + col]  = value;
      written[row*SIDE + col] = 1'b1;
    endfunction

    // Apply one accepted item to the shadow frame and queue its result.
    function void note_command(paint_cmd_t c);
      paint_result_t res;
      longint        cx;
      longint        cy;
      longint        rad;
      longint        outer;
      longint        inner;
      longint        dx;
      longint        dy;
      longint        d2;
      bit            filled;
      int unsigned   col;
      int unsigned   row;
      res.status      = STATUS_OK;
      res.pixel_value = '0;
      case (c.kind)
        KIND_CLEAR: begin
          for (row = 0; row < rows(); row++) begin
            for (col = 0; col < cols(); col++) begin
              put_pixel(col, row, background);
            end
          end
        end
        KIND_CIRCLE: begin
          cx  = c.center_x;
          cy  = c.center_y;
          rad = c.radius;
          if (rad < ONE_Q8 ||
              (c.shape_char != SHAPE_FILLED && c.shape_char != SHAPE_OUTLINE)) begin
            res.status = STATUS_BAD_SHAPE;
          end else begin
            // Squared distances against the squared radii; the outline
            // keeps only the one-unit band just inside the edge.
            filled = (c.shape_char == SHAPE_FILLED);
            outer  = rad * rad;
            inner  = (rad - ONE_Q8) * (rad - ONE_Q8);
            for (row = 0; row < rows(); row++) begin
              dy = longint'(row) * ONE_Q8 - cy;
              for (col = 0; col < cols(); col++) begin
                dx = longint'(col) * ONE_Q8 - cx;
                d2 = dx * dx + dy * dy;
                if (d2 <= outer && (filled || d2 > inner)) begin
                  put_pixel(col, row, c.paint_char);
                end
              end
            end
          end
        end
        KIND_READ: begin
          if (int'(c.read_col) >= cols() || int'(c.read_row) >= rows()) begin
            res.status = STATUS_RANGE;
          end else begin
            res.pixel_value = pixels[int'(c.read_row)*SIDE + int'(c.read_col)];
          end
        end
        default: begin
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void flag(string field, logic [7:0] want_v, logic [7:0] got_v);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want_v,
                 got_v);
      end
    endfunction

    // Compare one result item with the oldest prediction.
    function void check_result(paint_result_t got);
      paint_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result with none expected: status %0h, pixel %0h", $realtime,
                   got.status, got.pixel_value);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          flag("status", want.status, got.status);
        end
        if (got.pixel_value !== want.pixel_value) begin
          flag("pixel_value", want.pixel_value, got.pixel_value);
        end
      end
    endfunction
  endclass

endpackage

FILE: sim/circle_raster_painter_top_tb.sv
`timescale 1ns / 100ps

module circle_raster_painter_top_tb;
  import crp_pkg::*;
  import paint_check_pkg::*;

  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned ITEMS_PER_PHASE = 14;
  localparam int unsigned RANDOM_PHASES   = 5;

  logic            clk = 1'b0;
  logic            rst_n;
  bit              idle_on;
  bit              hold_request;
  frame_scoreboard sb;

  crp_in_if  in_if ();
  crp_out_if out_if ();
  crp_cfg_if cfg_if ();

  circle_raster_painter_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog for a hung block.
  initial begin
    #40_000_000;
    $display("circle_raster_painter_top_tb NOT OK");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : result_receiver
    int unsigned held;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_if.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Check every accepted result item.
  always @(posedge clk) begin : result_monitor
    paint_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.status      = out_if.status;
      got.pixel_value = out_if.pixel_value;
      sb.check_result(got);
    end
  end

  // An item of the given kind with every other field random.
  function automatic paint_cmd_t noise_cmd(logic [KIND_W-1:0] kind);
    paint_cmd_t c;
    c.kind       = kind;
    c.shape_char = CHAR_W'($urandom);
    c.paint_char = CHAR_W'($urandom);
    c.center_x   = COORD_W'($urandom);
    c.center_y   = COORD_W'($urandom);
    c.radius     = COORD_W'($urandom);
    c.read_col   = IDX8_W'($urandom);
    c.read_row   = IDX8_W'($urandom);
    return c;
  endfunction

  // Offer one item, possibly after a short gap, and wait until it is taken.
  task automatic send_command(paint_cmd_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= c.kind;
    in_if.shape_char <= c.shape_char;
    in_if.paint_char <= c.paint_char;
    in_if.center_x   <= c.center_x;
    in_if.center_y   <= c.center_y;
    in_if.radius     <= c.radius;
    in_if.read_col   <= c.read_col;
    in_if.read_row   <= c.read_row;
    do @(posedge clk); while (!in_if.ready);
    sb.note_command(c);
  endtask

  task automatic send_clear();
    send_command(noise_cmd(KIND_CLEAR));
  endtask

  task automatic send_circle(logic [CHAR_W-1:0] shape, logic [CHAR_W-1:0] paint,
                             logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                             logic signed [COORD_W-1:0] r);
    paint_cmd_t c;
    c            = noise_cmd(KIND_CIRCLE);
    c.shape_char = shape;
    c.paint_char = paint;
    c.center_x   = cx;
    c.center_y   = cy;
    c.radius     = r;
    send_command(c);
  endtask

  task automatic send_read(logic [IDX8_W-1:0] col, logic [IDX8_W-1:0] row);
    paint_cmd_t c;
    c          = noise_cmd(KIND_READ);
    c.read_col = col;
    c.read_row = row;
    send_command(c);
  endtask

  // Stop offering items and wait for every predicted result.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write all three registers back to back; the block must be idle.
  task automatic write_config(logic [CFG_DAT_W-1:0] w, logic [CFG_DAT_W-1:0] h,
                              logic [CFG_DAT_W-1:0] bg);
    logic [CFG_IDX_W-1:0] idx_list [3];
    logic [CFG_DAT_W-1:0] data_list [3];
    idx_list  = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_BACKGROUND};
    data_list = '{w, h, bg};
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx_list[i];
      cfg_if.data  <= data_list[i];
      do @(posedge clk); while (!cfg_if.ready);
      sb.set_register(idx_list[i], data_list[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Read a written pixel or one off the frame, or send an unused kind.
  task automatic send_random_read();
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    bit          outside;
    w       = sb.cols();
    h       = sb.rows();
    outside = (w == 0 || h == 0 || $urandom_range(0, 4) == 0);
    if (!outside) begin
      col     = $urandom_range(0, w - 1);
      row     = $urandom_range(0, h - 1);
      outside = !sb.is_written(col, row);
    end
    if (outside) begin
      if (w < SIDE && (h == SIDE || $urandom_range(0, 1) == 1)) begin
        col = $urandom_range(w, SIDE - 1);
        row = $urandom_range(0, SIDE - 1);
      end else if (h < SIDE) begin
        row = $urandom_range(h, SIDE - 1);
        col = $urandom_range(0, SIDE - 1);
      end else begin
        send_command(noise_cmd(KIND_UNUSED));
        return;
      end
    end
    send_read(IDX8_W'(col), IDX8_W'(row));
  endtask

  // Mostly circles that land on the frame; some rejected, some raw noise.
  task automatic send_random_circle();
    int unsigned       span;
    int unsigned       pick;
    logic [CHAR_W-1:0] shape;
    int                cx;
    int                cy;
    int                r;
    span  = (sb.cols() > sb.rows()) ? sb.cols() : sb.rows();
    pick  = $urandom_range(0, 99);
    shape = ($urandom_range(0, 1) == 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
    cx    = int'($urandom_range(0, (sb.cols() + 8) * 256)) - 1024;
    cy    = int'($urandom_range(0, (sb.rows() + 8) * 256)) - 1024;
    r     = int'($urandom_range(256, span * 128 + 768));
    if (pick < 8) begin
      r = ONE_Q8;
    end else if (pick < 16) begin
      r = int'($urandom_range(0, 255));
    end else if (pick < 22) begin
      r = -int'($urandom_range(1, 8388608));
    end else if (pick < 32) begin
      do shape = CHAR_W'($urandom); while (shape == SHAPE_FILLED || shape == SHAPE_OUTLINE);
    end else if (pick < 42) begin
      cx = int'($urandom);
      cy = int'($urandom);
      r  = int'($urandom);
    end
    send_circle(shape, CHAR_W'($urandom), COORD_W'(cx), COORD_W'(cy), COORD_W'(r));
  endtask

  // One random phase: new geometry, a clear, then a mix of items.
  task automatic random_phase(int unsigned n_items, bit with_hold);
    int unsigned          pick;
    logic [CFG_DAT_W-1:0] w;
    logic [CFG_DAT_W-1:0] h;
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      w = CFG_DAT_W'($urandom_range(256, 511));
      h = CFG_DAT_W'($urandom_range(1, 4));
    end else if (pick == 1) begin
      h = CFG_DAT_W'($urandom_range(256, 511));
      w = CFG_DAT_W'($urandom_range(1, 4));
    end else begin
      w = CFG_DAT_W'($urandom_range(1, 40));
      h = CFG_DAT_W'($urandom_range(1, 40));
    end
    write_config(w, h, CFG_DAT_W'($urandom_range(0, 255)));
    send_clear();
    // Hold results back while reads keep coming, so the input stalls.
    if (with_hold) begin
      wait_drained();
      hold_request = 1'b1;
    end
    repeat (n_items - 1) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_clear();
      end else if (pick < 50 && !with_hold) begin
        send_random_circle();
      end else if (pick < 96) begin
        send_random_read();
      end else begin
        send_command(noise_cmd(KIND_UNUSED));
      end
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int unsigned phase;
    sb               = new();
    idle_on          = 1'b1;
    hold_request     = 1'b0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_CLEAR;
    in_if.shape_char = '0;
    in_if.paint_char = '0;
    in_if.center_x   = '0;
    in_if.center_y   = '0;
    in_if.radius     = '0;
    in_if.read_col   = '0;
    in_if.read_row   = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_FRAME_WIDTH;
    cfg_if.data      = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full frame at the reset settings: one clear and one filled disc.
    send_clear();
    send_circle(SHAPE_FILLED, 8'h41, 128 * 256, 128 * 256, 20 * 256);
    send_read(0, 0);
    send_read(255, 255);
    send_read(128, 128);
    send_read(128, 148);
    send_read(128, 149);
    wait_drained();

    // Small frame: unit outline, rejected circles, extreme fields.
    write_config(16, 12, 8'hFF);
    send_clear();
    send_circle(SHAPE_OUTLINE, 8'h00, 5 * 256, 5 * 256, ONE_Q8);
    send_circle(SHAPE_OUTLINE, 8'h6F, 8 * 256 + 128, 6 * 256 - 64, 4 * 256 + 100);
    send_circle(SHAPE_FILLED, 8'h78, 3 * 256, 3 * 256, 255);
    send_circle(SHAPE_FILLED, 8'h78, 3 * 256, 3 * 256, -8388608);
    send_circle(8'h78, 8'h78, 3 * 256, 3 * 256, 3 * 256);
    send_circle(SHAPE_FILLED, 8'hAA, 8388607, -8388608, 8388607);
    send_circle(SHAPE_OUTLINE, 8'h55, -8388608, -8388608, 8388607);
    send_command(noise_cmd(KIND_UNUSED));
    send_read(5, 5);
    send_read(5, 4);
    send_read(15, 11);
    send_read(16, 0);
    send_read(0, 12);
    wait_drained();

    // Empty frame: nothing is touched and every read is out of range.
    write_config(0, 5, 8'h00);
    send_clear();
    send_circle(SHAPE_FILLED, 8'h11, 0, 0, 4 * 256);
    send_read(0, 0);
    wait_drained();

    // Width above the maximum side, single row.
    write_config(300, 1, 8'h7E);
    send_clear();
    send_circle(SHAPE_OUTLINE, 8'h22, 100 * 256, 0, 50 * 256 + 37);
    send_read(255, 0);
    send_read(150, 0);
    send_read(0, 1);
    wait_drained();

    // Single column of full height.
    write_config(1, 256, 8'h01);
    send_clear();
    send_circle(SHAPE_FILLED, 8'h33, 0, 200 * 256, 10 * 256);
    send_read(0, 255);
    send_read(0, 190);
    send_read(1, 0);
    wait_drained();

    // Random phases; the last one runs without any idling.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase != RANDOM_PHASES - 1);
      random_phase(ITEMS_PER_PHASE, phase == 2);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("circle_raster_painter_top_tb OK");
    end else begin
      $display("circle_raster_painter_top_tb NOT OK");
    end
    $finish;
  end

endmodule
